[rtl/per_source_traffic_counter_top_macros.svh]
// Assertion macros used by the checker file.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef PER_SOURCE_TRAFFIC_COUNTER_TOP_MACROS_SVH
`define PER_SOURCE_TRAFFIC_COUNTER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSTC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("traffic counter check failed");

// The consequent must hold in the cycle after the antecedent.
`define PSTC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("traffic counter check failed");

`endif

[rtl/pstc_pkg.sv]
package pstc_pkg;

  // Table size and the widths that follow from it.
  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);

  // Packets from this first octet are loopback traffic and are not counted.
  localparam logic [7:0] LOOPBACK_OCTET = 8'd127;

  // Operation codes of an input word.
  localparam logic [1:0] OP_PACKET = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  // Status codes of a result word.
  localparam logic [2:0] ST_HIT  = 3'd0;
  localparam logic [2:0] ST_NEW  = 3'd1;
  localparam logic [2:0] ST_LOOP = 3'd2;
  localparam logic [2:0] ST_FULL = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  // One table entry as stored and read back.
  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] count;
    logic [63:0] bytes;
  } entry_t;

  // Write port of the table.
  typedef struct packed {
    logic             we_addr;
    logic             we_cnt;
    logic [IDX_W-1:0] idx;
    entry_t           data;
  } wr_t;

  // Result word handed to the output register.
  typedef struct packed {
    logic              load;
    logic [2:0]        status;
    logic [5:0]        idx;
    logic              valid;
    entry_t            data;
    logic [FILL_W-1:0] used;
  } res_t;

endpackage

[rtl/pstc_table.sv]
module pstc_table (
  input  logic                        clk,
  input  pstc_pkg::wr_t               wr,
  input  logic [pstc_pkg::IDX_W-1:0]  rd_idx,
  output pstc_pkg::entry_t            rd_data
);

  logic [31:0] addr_mem  [pstc_pkg::TABLE_ENTRIES];
  logic [31:0] count_mem [pstc_pkg::TABLE_ENTRIES];
  logic [63:0] bytes_mem [pstc_pkg::TABLE_ENTRIES];

  // Single write port; the address field is only written for a new entry.
  always_ff @(posedge clk) begin
    if (wr.we_addr) begin
      addr_mem[wr.idx] <= wr.data.addr;
    end
    if (wr.we_cnt) begin
      count_mem[wr.idx] <= wr.data.count;
      bytes_mem[wr.idx] <= wr.data.bytes;
    end
  end

  // Registered read of all three fields at one address.
  always_ff @(posedge clk) begin
    rd_data.addr  <= addr_mem[rd_idx];
    rd_data.count <= count_mem[rd_idx];
    rd_data.bytes <= bytes_mem[rd_idx];
  end

endmodule

[rtl/pstc_ctrl.sv]
module pstc_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [1:0]                  opcode,
  input  logic [31:0]                 src_addr,
  input  logic [15:0]                 pkt_len,
  input  logic [5:0]                  read_index,
  output logic                        busy,
  output logic [pstc_pkg::IDX_W-1:0]  rd_idx,
  input  pstc_pkg::entry_t            rd_data,
  output pstc_pkg::wr_t               wr,
  output pstc_pkg::res_t              res
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_UPDATE = 5'b00100,
    S_CLEAR  = 5'b01000,
    S_READ   = 5'b10000
  } state_t;

  state_t                         state, state_next;
  logic [pstc_pkg::FILL_W-1:0]    fill, fill_next;
  logic [pstc_pkg::FILL_W-1:0]    scan, scan_next;
  logic                           pipe_v, pipe_v_next;
  logic [pstc_pkg::IDX_W-1:0]     pipe_idx, pipe_idx_next;
  logic [pstc_pkg::IDX_W-1:0]     clr_idx, clr_idx_next;
  logic [pstc_pkg::IDX_W-1:0]     hit_idx, hit_idx_next;
  logic [5:0]                     key_idx, key_idx_next;
  logic [31:0]                    key_addr, key_addr_next;
  logic [15:0]                    key_len, key_len_next;
  pstc_pkg::entry_t               hit, hit_next;

  logic                           accept;
  logic                           issue;
  logic                           match;
  logic [31:0]                    count_inc;
  logic [64:0]                    bytes_sum;
  logic [63:0]                    bytes_inc;

  assign busy   = (state != S_IDLE);
  assign accept = start && (state == S_IDLE);

  // While idle the read port looks at the requested index so the registered data is ready in S_READ.
  assign rd_idx = (state == S_IDLE) ? pstc_pkg::IDX_W'(read_index)
                                    : scan[pstc_pkg::IDX_W-1:0];

  // Shared compare: one stored address against the key per cycle.
  assign issue = (scan < fill);
  assign match = pipe_v && (rd_data.addr == key_addr);

  // Saturating counter update of a hit entry.
  assign count_inc = (&hit.count) ? hit.count : hit.count + 32'd1;
  assign bytes_sum = {1'b0, hit.bytes} + 65'(key_len);
  assign bytes_inc = bytes_sum[64] ? '1 : bytes_sum[63:0];

  // Sequencer.
  always_comb begin
    state_next    = state;
    fill_next     = fill;
    scan_next     = scan;
    pipe_v_next   = 1'b0;
    pipe_idx_next = pipe_idx;
    clr_idx_next  = clr_idx;
    hit_idx_next  = hit_idx;
    key_idx_next  = key_idx;
    key_addr_next = key_addr;
    key_len_next  = key_len;
    hit_next      = hit;
    wr            = '0;
    res           = '0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          key_addr_next = src_addr;
          key_len_next  = pkt_len;
          key_idx_next  = read_index;
          case (opcode)
            pstc_pkg::OP_PACKET: begin
              if (src_addr[31:24] == pstc_pkg::LOOPBACK_OCTET) begin
                res.load   = 1'b1;
                res.status = pstc_pkg::ST_LOOP;
              end else begin
                state_next = S_SEARCH;
                scan_next  = '0;
              end
            end
            pstc_pkg::OP_CLEAR: begin
              state_next   = S_CLEAR;
              clr_idx_next = '0;
            end
            pstc_pkg::OP_READ: begin
              if (32'(read_index) < 32'(fill)) begin
                state_next = S_READ;
              end else begin
                res.load   = 1'b1;
                res.status = pstc_pkg::ST_DONE;
                res.idx    = read_index;
              end
            end
            default: begin
              res.load   = 1'b1;
              res.status = pstc_pkg::ST_DONE;
            end
          endcase
        end
      end

      S_SEARCH: begin
        if (match) begin
          state_next   = S_UPDATE;
          hit_next     = rd_data;
          hit_idx_next = pipe_idx;
        end else if (issue) begin
          scan_next     = scan + 1'b1;
          pipe_v_next   = 1'b1;
          pipe_idx_next = scan[pstc_pkg::IDX_W-1:0];
        end else if (fill == pstc_pkg::FILL_W'(pstc_pkg::TABLE_ENTRIES)) begin
          // Miss with every entry in use: drop the packet.
          state_next = S_IDLE;
          res.load   = 1'b1;
          res.status = pstc_pkg::ST_FULL;
        end else begin
          // Miss: append a new entry at the fill level.
          state_next       = S_IDLE;
          fill_next        = fill + 1'b1;
          wr.we_addr       = 1'b1;
          wr.we_cnt        = 1'b1;
          wr.idx           = fill[pstc_pkg::IDX_W-1:0];
          wr.data.addr     = key_addr;
          wr.data.count    = 32'd1;
          wr.data.bytes    = 64'(key_len);
          res.load         = 1'b1;
          res.status       = pstc_pkg::ST_NEW;
          res.idx          = 6'(fill);
          res.valid        = 1'b1;
          res.data         = wr.data;
        end
      end

      S_UPDATE: begin
        state_next    = S_IDLE;
        wr.we_cnt     = 1'b1;
        wr.idx        = hit_idx;
        wr.data.addr  = hit.addr;
        wr.data.count = count_inc;
        wr.data.bytes = bytes_inc;
        res.load      = 1'b1;
        res.status    = pstc_pkg::ST_HIT;
        res.idx       = 6'(hit_idx);
        res.valid     = 1'b1;
        res.data      = wr.data;
      end

      S_CLEAR: begin
        // One entry per cycle through the write port; addresses are kept.
        wr.we_cnt = 1'b1;
        wr.idx    = clr_idx;
        if (clr_idx == pstc_pkg::IDX_W'(pstc_pkg::TABLE_ENTRIES - 1)) begin
          state_next = S_IDLE;
          res.load   = 1'b1;
          res.status = pstc_pkg::ST_DONE;
        end else begin
          clr_idx_next = clr_idx + 1'b1;
        end
      end

      S_READ: begin
        state_next = S_IDLE;
        res.load   = 1'b1;
        res.status = pstc_pkg::ST_DONE;
        res.idx    = key_idx;
        res.valid  = 1'b1;
        res.data   = rd_data;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    res.used = fill_next;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      fill   <= '0;
      scan   <= '0;
      pipe_v <= 1'b0;
    end else begin
      state  <= state_next;
      fill   <= fill_next;
      scan   <= scan_next;
      pipe_v <= pipe_v_next;
    end
  end

  // Working registers of the current word.
  always_ff @(posedge clk) begin
    pipe_idx <= pipe_idx_next;
    clr_idx  <= clr_idx_next;
    hit_idx  <= hit_idx_next;
    key_idx  <= key_idx_next;
    key_addr <= key_addr_next;
    key_len  <= key_len_next;
    hit      <= hit_next;
  end

endmodule

[rtl/per_source_traffic_counter_top.sv]
// Channel   Handshake            Payload
// input     start / busy         opcode, src_addr, pkt_len, read_index
// result    done (one cycle)     status, entry_index, entry_valid, entry_addr,
//                                packet_count, byte_total, used_entries
//
// done is registered and is high in the cycle after the controller loads the result word.
// Loopback packets, reads of unused entries and unknown opcodes finish in the accept cycle; a
// read of a used entry waits in S_READ on the registered table read.
// A clear writes zero counts to one entry per cycle on the write port, keeping addresses.
// A packet ends in an append or a drop on a miss and an update in S_UPDATE on a hit, the
// single address comparator walking the table one entry per cycle.
// Synchronous reset empties the table; the receiver cannot stall results.
module per_source_traffic_counter_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [31:0] src_addr,
  input  logic [15:0] pkt_len,
  input  logic [5:0]  read_index,
  output logic        done,
  output logic [2:0]  status,
  output logic [5:0]  entry_index,
  output logic        entry_valid,
  output logic [31:0] entry_addr,
  output logic [31:0] packet_count,
  output logic [63:0] byte_total,
  output logic [6:0]  used_entries
);

  logic [pstc_pkg::IDX_W-1:0] rd_idx;
  pstc_pkg::entry_t           rd_data;
  pstc_pkg::wr_t              wr;
  pstc_pkg::res_t             res;

  pstc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .opcode     (opcode),
    .src_addr   (src_addr),
    .pkt_len    (pkt_len),
    .read_index (read_index),
    .busy       (busy),
    .rd_idx     (rd_idx),
    .rd_data    (rd_data),
    .wr         (wr),
    .res        (res)
  );

  pstc_table u_table (
    .clk     (clk),
    .wr      (wr),
    .rd_idx  (rd_idx),
    .rd_data (rd_data)
  );

  // Result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res.load;
    end
  end

  // Result word register.
  always_ff @(posedge clk) begin
    if (res.load) begin
      status       <= res.status;
      entry_index  <= res.idx;
      entry_valid  <= res.valid;
      entry_addr   <= res.data.addr;
      packet_count <= res.data.count;
      byte_total   <= res.data.bytes;
      used_entries <= 7'(res.used);
    end
  end

endmodule

[rtl/pstc_checker.sv]
`include "per_source_traffic_counter_top_macros.svh"

module pstc_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [1:0]  opcode,
  input logic [31:0] src_addr,
  input logic [15:0] pkt_len,
  input logic [5:0]  read_index,
  input logic        done,
  input logic [2:0]  status,
  input logic [5:0]  entry_index,
  input logic        entry_valid,
  input logic [31:0] entry_addr,
  input logic [31:0] packet_count,
  input logic [63:0] byte_total,
  input logic [6:0]  used_entries
);

  // An accepted word either finishes at once or keeps the block busy.
  `PSTC_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done)

  // A result is only shown once the block has gone idle.
  `PSTC_ASSERT_SAME(a_done_idle, done, !busy)

  // Counted entries always report a live entry with at least one packet.
  `PSTC_ASSERT_SAME(a_counted_live,
                    done && (status == pstc_pkg::ST_HIT || status == pstc_pkg::ST_NEW),
                    entry_valid && (packet_count != 32'd0))

  // A new entry is always the last one in use.
  `PSTC_ASSERT_SAME(a_new_is_last, done && (status == pstc_pkg::ST_NEW),
                    used_entries == ({1'b0, entry_index} + 7'd1))

  // Loopback and dropped packets report an empty entry.
  `PSTC_ASSERT_SAME(a_drop_empty,
                    done && (status == pstc_pkg::ST_LOOP || status == pstc_pkg::ST_FULL),
                    !entry_valid && (packet_count == 32'd0) && (byte_total == 64'd0))

endmodule

bind per_source_traffic_counter_top pstc_checker u_pstc_checker (.*);
